// ===== rtl/core/sbf_pkg.sv =====
// shared constants for the spring force block
`timescale 1ns / 1ps
package sbf_pkg;
	localparam int SBF_FRAC_BITS   = 16;
	localparam int SBF_COORD_WIDTH = 32;
	localparam int K_WIDTH         = 32;
	localparam int REST_WIDTH      = 31;
	localparam int ADDR_WIDTH      = 4;
	localparam int DATA_WIDTH      = 32;

	localparam logic [31:0] K_RESET    = 32'h0001_0000;
	localparam logic [30:0] REST_RESET = 31'h0001_0000;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_K      = 2'd0;
	localparam logic [1:0] REG_REST   = 2'd1;
	localparam logic [1:0] REG_BUNGEE = 2'd2;
endpackage

// ===== rtl/core/sbf_sqrt_cell.sv =====
// one result bit of the pipelined restoring square root
`timescale 1ns / 1ps
module sbf_sqrt_cell #(
	parameter int SW  = 66,
	parameter int LW  = 33,
	parameter int PW  = 102,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [SW-1:0] rem_in,
	input  logic [LW-1:0] root_in,
	input  logic [PW-1:0] pay_in,
	output logic          v_out,
	output logic [SW-1:0] rem_out,
	output logic [LW-1:0] root_out,
	output logic [PW-1:0] pay_out
);
	logic [SW:0] trial;
	logic        take;

	// (r + 2^b)^2 - r^2
	assign trial = ((SW+1)'(root_in) << (BIT + 1)) + ((SW+1)'(1) << (2 * BIT));
	assign take  = ({1'b0, rem_in} >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= take ? (rem_in - trial[SW-1:0]) : rem_in;
			root_out <= take ? (root_in | (LW'(1) << BIT)) : root_in;
			pay_out  <= pay_in;
		end
	end
endmodule

// ===== rtl/core/sbf_div_cell.sv =====
// one quotient bit for the three axis divisions
`timescale 1ns / 1ps
module sbf_div_cell #(
	parameter int LW  = 33,
	parameter int RW  = 66,
	parameter int QW  = 33,
	parameter int BIT = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  logic [LW-1:0]        len_in,
	input  logic [3:0]           flg_in,
	input  logic [2:0][RW-1:0]   rem_in,
	input  logic [2:0][QW-1:0]   q_in,
	output logic                 v_out,
	output logic [LW-1:0]        len_out,
	output logic [3:0]           flg_out,
	output logic [2:0][RW-1:0]   rem_out,
	output logic [2:0][QW-1:0]   q_out
);
	logic [RW-1:0] dsub;

	assign dsub = RW'(len_in) << BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_out <= len_in;
			flg_out <= flg_in;
			for (int i = 0; i < 3; i++) begin
				if (rem_in[i] >= dsub) begin
					rem_out[i] <= rem_in[i] - dsub;
					q_out[i]   <= q_in[i] | (QW'(1) << BIT);
				end else begin
					rem_out[i] <= rem_in[i];
					q_out[i]   <= q_in[i];
				end
			end
		end
	end
endmodule

// ===== rtl/core/spring_bungee_force.sv =====
// spring force pipeline: top level
//
// Hooke's-law spring force between a particle and its partner, signed fixed point.
// Input channel in_valid/in_stall carries both positions; a transfer happens when
// in_valid is high and in_stall low. Output channel out_valid/out_stall carries the
// force vector with applied and saturated flags, one result per input.
// Stiffness, rest length and bungee mode sit in an APB register file at 0x0, 0x4
// and 0x8; write them only while the pipeline is empty.
// Throughput: one item per cycle while the skid register is empty. The depth of the
// pipeline is set mostly by the square-root cell row (one cell per root bit) and the
// divider cell row (one cell per quotient bit).
// When the receiver stalls the result holds and a skid register takes one more
// item; the whole pipeline then freezes and in_stall rises until it drains.
// Reset empties the pipeline and loads k = 1.0, rest = 1.0, bungee mode off.
`timescale 1ns / 1ps
module spring_bungee_force #(
	parameter int FRAC_BITS   = sbf_pkg::SBF_FRAC_BITS,
	parameter int COORD_WIDTH = sbf_pkg::SBF_COORD_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [sbf_pkg::ADDR_WIDTH-1:0]        paddr,
	input  logic [sbf_pkg::DATA_WIDTH-1:0]        pwdata,
	output logic [sbf_pkg::DATA_WIDTH-1:0]        prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [COORD_WIDTH-1:0]         pos_x,
	input  logic signed [COORD_WIDTH-1:0]         pos_y,
	input  logic signed [COORD_WIDTH-1:0]         pos_z,
	input  logic signed [COORD_WIDTH-1:0]         partner_x,
	input  logic signed [COORD_WIDTH-1:0]         partner_y,
	input  logic signed [COORD_WIDTH-1:0]         partner_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [COORD_WIDTH-1:0]         force_x,
	output logic signed [COORD_WIDTH-1:0]         force_y,
	output logic signed [COORD_WIDTH-1:0]         force_z,
	output logic                                  applied,
	output logic                                  saturated
);
	import sbf_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int LW = CW + 1;
	localparam int SW = 2 * LW;
	localparam int DW = (LW > REST_WIDTH) ? LW : REST_WIDTH;
	localparam int QW = DW;
	localparam int RW = LW + DW;
	localparam int FW = QW + K_WIDTH;
	localparam int PW = 3 * LW + 3;

	// configuration registers
	logic [K_WIDTH-1:0]    k_q;
	logic [REST_WIDTH-1:0] rest_q;
	logic                  bungee_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= K_RESET;
			rest_q   <= REST_RESET;
			bungee_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_K:      k_q      <= pwdata[K_WIDTH-1:0];
				REG_REST:   rest_q   <= pwdata[REST_WIDTH-1:0];
				REG_BUNGEE: bungee_q <= pwdata[0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_K:      prdata = k_q;
			REG_REST:   prdata = {1'b0, rest_q};
			REG_BUNGEE: prdata = {31'd0, bungee_q};
			default:    prdata = '0;
		endcase
	end

	// pipeline advances unless the skid register is occupied
	logic en;
	logic skid_v_q;
	assign en       = !skid_v_q;
	assign in_stall = !en;

	// s1: differences
	logic signed [LW-1:0]  d [3];
	logic [2:0][LW-1:0]    mag_s1;
	logic [2:0]            neg_s1;
	logic                  v_s1;

	assign d[0] = {pos_x[CW-1], pos_x} - {partner_x[CW-1], partner_x};
	assign d[1] = {pos_y[CW-1], pos_y} - {partner_y[CW-1], partner_y};
	assign d[2] = {pos_z[CW-1], pos_z} - {partner_z[CW-1], partner_z};

	// s2: squares, s3: sum
	logic [2:0][SW-1:0] sq_s2;
	logic [2:0][LW-1:0] mag_s2;
	logic [2:0]         neg_s2;
	logic               v_s2;
	logic [SW-1:0]      sum_s3;
	logic [2:0][LW-1:0] mag_s3;
	logic [2:0]         neg_s3;
	logic               v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= d[i][LW-1];
				mag_s1[i] <= d[i][LW-1] ? LW'(-d[i]) : LW'(d[i]);
				sq_s2[i]  <= mag_s1[i] * mag_s1[i];
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
		end
	end

	// square-root cell row, most significant root bit first
	logic          sq_v    [LW+1];
	logic [SW-1:0] sq_rem  [LW+1];
	logic [LW-1:0] sq_root [LW+1];
	logic [PW-1:0] sq_pay  [LW+1];

	assign sq_v[0]    = v_s3;
	assign sq_rem[0]  = sum_s3;
	assign sq_root[0] = '0;
	assign sq_pay[0]  = {neg_s3, mag_s3};

	for (genvar c = 0; c < LW; c++) begin : g_sqrt
		sbf_sqrt_cell #(.SW(SW), .LW(LW), .PW(PW), .BIT(LW - 1 - c)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (sq_v[c]),
			.rem_in  (sq_rem[c]),
			.root_in (sq_root[c]),
			.pay_in  (sq_pay[c]),
			.v_out   (sq_v[c+1]),
			.rem_out (sq_rem[c+1]),
			.root_out(sq_root[c+1]),
			.pay_out (sq_pay[c+1])
		);
	end

	logic [LW-1:0]      len;
	logic [2:0][LW-1:0] mag_r;
	logic [2:0]         neg_r;
	logic [DW-1:0]      len_e;
	logic [DW-1:0]      rest_e;

	assign len    = sq_root[LW];
	assign {neg_r, mag_r} = sq_pay[LW];
	assign len_e  = DW'(len);
	assign rest_e = DW'(rest_q);

	// s4: stretch and no-force cases
	logic [DW-1:0]      diff_s4;
	logic [LW-1:0]      len_s4;
	logic [2:0][LW-1:0] mag_s4;
	logic [2:0]         neg_s4;
	logic               kill_s4;
	logic               v_s4;
	// s5: |d_i| * stretch
	logic [2:0][RW-1:0] p_s5;
	logic [LW-1:0]      len_s5;
	logic [2:0]         neg_s5;
	logic               kill_s5;
	logic               v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v[LW];
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s4 <= (len_e >= rest_e) ? (len_e - rest_e) : (rest_e - len_e);
			kill_s4 <= (len == '0) || (bungee_q && (len_e < rest_e));
			len_s4  <= len;
			mag_s4  <= mag_r;
			neg_s4  <= neg_r;
			for (int i = 0; i < 3; i++) begin
				p_s5[i] <= mag_s4[i] * diff_s4;
			end
			len_s5  <= len_s4;
			neg_s5  <= neg_s4;
			kill_s5 <= kill_s4;
		end
	end

	// divider cell row, one quotient bit per cell
	logic               dv_v   [QW+1];
	logic [LW-1:0]      dv_len [QW+1];
	logic [3:0]         dv_flg [QW+1];
	logic [2:0][RW-1:0] dv_rem [QW+1];
	logic [2:0][QW-1:0] dv_q   [QW+1];

	assign dv_v[0]   = v_s5;
	assign dv_len[0] = len_s5;
	assign dv_flg[0] = {kill_s5, neg_s5};
	assign dv_rem[0] = p_s5;
	assign dv_q[0]   = '0;

	for (genvar c = 0; c < QW; c++) begin : g_div
		sbf_div_cell #(.LW(LW), .RW(RW), .QW(QW), .BIT(QW - 1 - c)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (dv_v[c]),
			.len_in (dv_len[c]),
			.flg_in (dv_flg[c]),
			.rem_in (dv_rem[c]),
			.q_in   (dv_q[c]),
			.v_out  (dv_v[c+1]),
			.len_out(dv_len[c+1]),
			.flg_out(dv_flg[c+1]),
			.rem_out(dv_rem[c+1]),
			.q_out  (dv_q[c+1])
		);
	end

	// s6: scale by k, s7: shift, clip and sign
	logic [2:0][FW-1:0] f_s6;
	logic [3:0]         flg_s6;
	logic               v_s6;
	logic [2:0][CW-1:0] frc_s7;
	logic               app_s7;
	logic               sat_s7;
	logic               v_s7;

	logic [2:0][FW-1:0] fm;
	logic [2:0][CW-1:0] lim;
	logic [2:0]         clip;
	logic [2:0][CW-1:0] fmc;
	logic [2:0][CW-1:0] frc;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fm[i]   = f_s6[i] >> FRAC_BITS;
			// result points opposite to d
			lim[i]  = flg_s6[i] ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			clip[i] = fm[i] > FW'(lim[i]);
			fmc[i]  = clip[i] ? lim[i] : fm[i][CW-1:0];
			frc[i]  = flg_s6[i] ? fmc[i] : CW'(-fmc[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= dv_v[QW];
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				f_s6[i] <= dv_q[QW][i] * k_q;
			end
			flg_s6 <= dv_flg[QW];
			if (flg_s6[3]) begin
				frc_s7 <= '0;
				app_s7 <= 1'b0;
				sat_s7 <= 1'b0;
			end else begin
				frc_s7 <= frc;
				app_s7 <= (fmc[0] != '0) || (fmc[1] != '0) || (fmc[2] != '0);
				sat_s7 <= |clip;
			end
		end
	end

	// output register plus skid register
	logic               out_v_q;
	logic [2:0][CW-1:0] out_frc_q;
	logic               out_app_q;
	logic               out_sat_q;
	logic [2:0][CW-1:0] skid_frc_q;
	logic               skid_app_q;
	logic               skid_sat_q;
	logic               take;
	logic               arrive;

	assign take   = out_v_q && !out_stall;
	assign arrive = en && v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (take) begin
					skid_v_q <= 1'b0;
				end
			end else if (arrive) begin
				out_v_q  <= 1'b1;
				skid_v_q <= out_v_q && !take;
			end else if (take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_frc_q <= skid_frc_q;
				out_app_q <= skid_app_q;
				out_sat_q <= skid_sat_q;
			end
		end else if (arrive) begin
			if (!out_v_q || take) begin
				out_frc_q <= frc_s7;
				out_app_q <= app_s7;
				out_sat_q <= sat_s7;
			end else begin
				skid_frc_q <= frc_s7;
				skid_app_q <= app_s7;
				skid_sat_q <= sat_s7;
			end
		end
	end

	assign out_valid = out_v_q;
	assign force_x   = out_frc_q[0];
	assign force_y   = out_frc_q[1];
	assign force_z   = out_frc_q[2];
	assign applied   = out_app_q;
	assign saturated = out_sat_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && out_stall))
		else $error("skid register filled without a stalled result");

	a_applied_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && applied) |-> (force_x != '0 || force_y != '0 || force_z != '0))
		else $error("applied flag set on an all-zero force");

	a_sat_implies_applied: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && saturated) |-> applied)
		else $error("saturated flag set without applied");
endmodule

// ===== test/tb_top.sv =====
// testbench for the spring force pipeline: directed table then random transfers
`timescale 1ns / 1ps
module tb_top;
	import sbf_pkg::*;

	localparam int W = SBF_COORD_WIDTH;
	localparam int FB = SBF_FRAC_BITS;
	localparam int LATENCY = 2 * W + 10;
	localparam int N_RANDOM = 1800;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic signed [W-1:0] fx;
		logic signed [W-1:0] fy;
		logic signed [W-1:0] fz;
		logic                app;
		logic                sat;
	} force_t;

	typedef struct {
		logic signed [W-1:0] p [3];
		logic signed [W-1:0] q [3];
		logic                known;
		force_t              res;
	} spring_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_WIDTH-1:0] paddr;
	logic [DATA_WIDTH-1:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [W-1:0] pos_x, pos_y, pos_z, partner_x, partner_y, partner_z;
	logic signed [W-1:0] force_x, force_y, force_z;
	logic applied, saturated;

	logic [31:0] stiffness;
	logic [30:0] rest_len;
	logic        bungee;

	force_t expected_forces [$];
	int     n_errors;
	longint cycles;

	spring_bungee_force DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.partner_x(partner_x), .partner_y(partner_y), .partner_z(partner_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.applied(applied), .saturated(saturated)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report(input string what, input logic [W-1:0] got, input logic [W-1:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		n_errors++;
	endtask

	// floor sqrt of a 66-bit sum of squares
	function automatic logic [33:0] root_of(input logic [65:0] n);
		logic [33:0] r;
		logic [33:0] c;
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (34'd1 << b);
			if ({34'd0, c} * {34'd0, c} <= {2'd0, n})
				r = c;
		end
		return r;
	endfunction

	function automatic force_t spring_force(input logic signed [W-1:0] p [3],
			input logic signed [W-1:0] q [3]);
		force_t r;
		logic signed [W:0] d [3];
		logic [W:0] mag [3];
		logic [65:0] sumsq;
		logic [33:0] len, diff;
		logic [127:0] quo, fm;
		logic [W-1:0] comp [3];
		logic [W:0] lim;
		r = '0;
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = {p[i][W-1], p[i]} - {q[i][W-1], q[i]};
			mag[i] = d[i][W] ? -d[i] : d[i];
			sumsq += {33'd0, mag[i]} * {33'd0, mag[i]};
		end
		len = root_of(sumsq);
		if (len == 0 || (bungee && len < {3'd0, rest_len}))
			return r;
		diff = (len >= rest_len) ? len - rest_len : rest_len - len;
		for (int i = 0; i < 3; i++) begin
			quo = ({95'd0, mag[i]} * {94'd0, diff}) / {94'd0, len};
			fm = (quo * {96'd0, stiffness}) >> FB;
			lim = d[i][W] ? {2'b00, {(W-1){1'b1}}} : {2'b01, {(W-1){1'b0}}};
			if (fm > {{(127-W){1'b0}}, lim}) begin
				fm = {{(127-W){1'b0}}, lim};
				r.sat = 1;
			end
			if (fm != 0)
				r.app = 1;
			comp[i] = d[i][W] ? fm[W-1:0] : -fm[W-1:0];
		end
		r.fx = comp[0];
		r.fy = comp[1];
		r.fz = comp[2];
		return r;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_K: stiffness = v;
			REG_REST: rest_len = v[30:0];
			default: bungee = v[0];
		endcase
	endtask

	task automatic drain;
		while (expected_forces.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send(input logic signed [W-1:0] p [3], input logic signed [W-1:0] q [3],
			input logic known, input force_t want);
		force_t pred;
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
				@(posedge clk);
		end
		pred = spring_force(p, q);
		if (known && pred != want)
			$display("table row disagrees with prediction at cycle %0d", cycles);
		pos_x <= p[0]; pos_y <= p[1]; pos_z <= p[2];
		partner_x <= q[0]; partner_y <= q[1]; partner_z <= q[2];
		in_valid <= 1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_forces.push_back(known ? want : pred);
	endtask

	// output stall pattern
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 0;
		else if ($urandom_range(0, 5) == 0)
			out_stall <= ($urandom_range(0, 3) == 0);
		else if ($urandom_range(0, 1) == 0)
			out_stall <= 0;
	end

	always @(posedge clk) begin
		force_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_forces.size() == 0) begin
				report("unexpected transfer", force_x, 0);
			end else begin
				want = expected_forces.pop_front();
				if (force_x !== want.fx) report("force_x", force_x, want.fx);
				if (force_y !== want.fy) report("force_y", force_y, want.fy);
				if (force_z !== want.fz) report("force_z", force_z, want.fz);
				if (applied !== want.app) report("applied", applied, want.app);
				if (saturated !== want.sat) report("saturated", saturated, want.sat);
			end
		end
	end

	function automatic logic signed [W-1:0] rnd_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
			2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
		endcase
	endfunction

	localparam logic signed [W-1:0] MX = 32'sh7fff_ffff;
	localparam logic signed [W-1:0] MN = 32'sh8000_0000;
	localparam logic signed [W-1:0] ONE = 32'sh0001_0000;

	spring_row_t dir_rows [10];

	initial begin
		logic signed [W-1:0] p [3];
		logic signed [W-1:0] q [3];
		int mode;
		n_errors = 0; cycles = 0;
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; out_stall = 0;
		pos_x = 0; pos_y = 0; pos_z = 0; partner_x = 0; partner_y = 0; partner_z = 0;
		stiffness = K_RESET; rest_len = REST_RESET; bungee = 0;
		// zero separation, at rest, stretched, compressed, extremes
		dir_rows[0] = '{'{0, 0, 0}, '{0, 0, 0}, 1, '0};
		dir_rows[1] = '{'{ONE, 0, 0}, '{0, 0, 0}, 1, '0};
		dir_rows[2] = '{'{2 * ONE, 0, 0}, '{0, 0, 0}, 1, '{-ONE, 0, 0, 1, 0}};
		dir_rows[3] = '{'{0, 0, 0}, '{0, 3 * ONE, 0}, 1, '{0, 2 * ONE, 0, 1, 0}};
		dir_rows[4] = '{'{0, 0, ONE / 2}, '{0, 0, 0}, 0, '0};
		dir_rows[5] = '{'{MX, MX, MX}, '{MN, MN, MN}, 0, '0};
		dir_rows[6] = '{'{MN, MN, MN}, '{MX, MX, MX}, 0, '0};
		dir_rows[7] = '{'{MX, MN, 0}, '{MN, MX, 0}, 0, '0};
		dir_rows[8] = '{'{MX, 0, 0}, '{MX, 0, 0}, 1, '0};
		dir_rows[9] = '{'{3, -5, 7}, '{-1, 2, 0}, 0, '0};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir_rows[i])
			send(dir_rows[i].p, dir_rows[i].q, dir_rows[i].known, dir_rows[i].res);
		in_valid <= 0;
		drain();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(REG_K, 32'hffff_ffff); write_reg(REG_REST, 0);
					write_reg(REG_BUNGEE, 1); end
				1: begin write_reg(REG_K, 0); write_reg(REG_REST, 32'h7fff_ffff);
					write_reg(REG_BUNGEE, 0); end
				2: begin write_reg(REG_K, 32'h0004_0000); write_reg(REG_REST, 32'h0002_0000);
					write_reg(REG_BUNGEE, 1); end
				3: begin write_reg(REG_BUNGEE, 0); write_reg(REG_REST, 32'h7fff_ffff); end
				default: begin write_reg(REG_K, $urandom); write_reg(REG_REST, $urandom_range(0, 32'h0008_0000));
					write_reg(REG_BUNGEE, $urandom_range(0, 1)); end
			endcase
			for (int n = 0; n < N_RANDOM / 6; n++) begin
				mode = $urandom_range(0, 5);
				for (int a = 0; a < 3; a++) begin
					p[a] = rnd_coord(mode);
					q[a] = rnd_coord(mode);
				end
				if ($urandom_range(0, 40) == 0) q = p;
				send(p, q, 0, '0);
				if (n == 100) begin
					in_valid <= 0;
					while (expected_forces.size() != 0) @(posedge clk);
				end
			end
			in_valid <= 0;
			drain();
		end
		if (n_errors == 0 && expected_forces.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/sbf_pkg.sv
rtl/core/sbf_sqrt_cell.sv
rtl/core/sbf_div_cell.sv
rtl/core/spring_bungee_force.sv
test/tb_top.sv
